@@ src/tce_pkg.sv @@
// Shared constants, codes and types of the text console engine.
package tce_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	localparam int MODE_W    = 3;
	localparam int CH_W      = 8;
	localparam int ROW_W     = 5;
	localparam int COL_W     = 7;
	localparam int ATTR_W    = 8;
	localparam int CELL_W    = CH_W + ATTR_W;
	localparam int TDATA_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CH_W-1:0] CH_BLANK   = 8'h08;
	localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CH_W-1:0] CH_ERROR   = 8'h45;

	localparam logic [ATTR_W-1:0] RESET_DEFAULT_ATTR = 8'd15;
	localparam logic [ATTR_W-1:0] RESET_ERROR_ATTR   = 8'd244;

	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 2'd1;

	localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [COL_W:0]    COLS_X   = (COL_W + 1)'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W:0]   ADDR_COLS = (ADDR_W + 1)'(COLUMNS);
	localparam logic [ROW_W+COL_W:0] MUL_COLS = (ROW_W + COL_W + 1)'(COLUMNS);

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT_CUR   = 3'd0,
		MODE_PUT_POS   = 3'd1,
		MODE_BACKSPACE = 3'd2,
		MODE_CLEAR     = 3'd3,
		MODE_READ      = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SCROLL,
		ST_FILL
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CH_W-1:0]   ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ATTR_W-1:0] attr;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              error;
		logic              scrolled;
		logic [CH_W-1:0]   cell_char;
		logic [ATTR_W-1:0] cell_attr;
	} result_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] wr_data;
		logic [ROW_W-1:0]  nrow;
		logic [COL_W-1:0]  ncol;
		logic              error;
		logic              scroll;
		logic              clear;
	} exec_t;

endpackage

@@ src/tce_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/tce_exec.sv @@
// Operation decode: cell address, write data, next cursor and flags of one item.
module tce_exec (
	input  tce_pkg::item_t                  item,
	input  logic [tce_pkg::ROW_W-1:0]       cur_row,
	input  logic [tce_pkg::COL_W-1:0]       cur_col,
	input  logic [tce_pkg::ATTR_W-1:0]      dflt_attr,
	input  logic [tce_pkg::ATTR_W-1:0]      err_attr,
	output tce_pkg::exec_t                  ex
);

	function automatic logic [tce_pkg::ADDR_W-1:0] cell_addr(
		input logic [tce_pkg::ROW_W-1:0] r,
		input logic [tce_pkg::COL_W-1:0] c
	);
		logic [tce_pkg::ROW_W+tce_pkg::COL_W:0] full;
		full = ({{(tce_pkg::COL_W + 1){1'b0}}, r} * tce_pkg::MUL_COLS)
			+ {{(tce_pkg::ROW_W + 1){1'b0}}, c};
		return full[tce_pkg::ADDR_W-1:0];
	endfunction

	logic [tce_pkg::ATTR_W-1:0] attr_eff;
	logic                       on_screen;
	logic [tce_pkg::ROW_W-1:0]  bs_row;
	logic [tce_pkg::COL_W-1:0]  bs_col;
	logic [tce_pkg::ROW_W-1:0]  p_row;
	logic [tce_pkg::COL_W-1:0]  p_col;
	logic [tce_pkg::ROW_W:0]    nx_row;
	logic [tce_pkg::COL_W-1:0]  nx_col;
	logic                       put_scroll;
	logic [tce_pkg::ROW_W-1:0]  put_row;
	logic [tce_pkg::CH_W-1:0]   put_ch;

	always_comb begin
		attr_eff = (item.attr == '0) ? dflt_attr : item.attr;
		on_screen = ({1'b0, item.row} < tce_pkg::ROWS_X) && ({1'b0, item.col} < tce_pkg::COLS_X);

		if (cur_row == '0 && cur_col == '0) begin
			bs_row = '0;
			bs_col = '0;
		end else if (cur_col == '0) begin
			bs_row = cur_row - {{(tce_pkg::ROW_W - 1){1'b0}}, 1'b1};
			bs_col = tce_pkg::COL_LAST;
		end else begin
			bs_row = cur_row;
			bs_col = cur_col - {{(tce_pkg::COL_W - 1){1'b0}}, 1'b1};
		end

		if (tce_pkg::mode_t'(item.mode) == tce_pkg::MODE_PUT_POS) begin
			p_row = item.row;
			p_col = item.col;
		end else begin
			p_row = cur_row;
			p_col = cur_col;
		end

		if (item.ch == tce_pkg::CH_NEWLINE) begin
			nx_row = {1'b0, p_row} + {{tce_pkg::ROW_W{1'b0}}, 1'b1};
			nx_col = '0;
		end else if (item.ch == tce_pkg::CH_BLANK) begin
			nx_row = {1'b0, p_row};
			nx_col = p_col;
		end else if (p_col == tce_pkg::COL_LAST) begin
			nx_row = {1'b0, p_row} + {{tce_pkg::ROW_W{1'b0}}, 1'b1};
			nx_col = '0;
		end else begin
			nx_row = {1'b0, p_row};
			nx_col = p_col + {{(tce_pkg::COL_W - 1){1'b0}}, 1'b1};
		end
		put_scroll = (nx_row == tce_pkg::ROWS_X);
		put_row = put_scroll ? tce_pkg::ROW_LAST : nx_row[tce_pkg::ROW_W-1:0];
		put_ch = (item.ch == tce_pkg::CH_BLANK) ? tce_pkg::CH_SPACE : item.ch;

		ex.wr_en   = 1'b0;
		ex.rd_en   = 1'b0;
		ex.addr    = cell_addr(p_row, p_col);
		ex.wr_data = {attr_eff, put_ch};
		ex.nrow    = cur_row;
		ex.ncol    = cur_col;
		ex.error   = 1'b0;
		ex.scroll  = 1'b0;
		ex.clear   = 1'b0;

		unique case (tce_pkg::mode_t'(item.mode))
			tce_pkg::MODE_PUT_CUR: begin
				ex.wr_en  = (item.ch != tce_pkg::CH_NEWLINE);
				ex.nrow   = put_row;
				ex.ncol   = nx_col;
				ex.scroll = put_scroll;
			end
			tce_pkg::MODE_PUT_POS: begin
				if (on_screen) begin
					ex.wr_en  = (item.ch != tce_pkg::CH_NEWLINE);
					ex.nrow   = put_row;
					ex.ncol   = nx_col;
					ex.scroll = put_scroll;
				end else begin
					ex.wr_en   = 1'b1;
					ex.addr    = tce_pkg::LAST_CELL;
					ex.wr_data = {err_attr, tce_pkg::CH_ERROR};
					ex.error   = 1'b1;
				end
			end
			tce_pkg::MODE_BACKSPACE: begin
				ex.wr_en   = 1'b1;
				ex.addr    = cell_addr(bs_row, bs_col);
				ex.wr_data = {dflt_attr, tce_pkg::CH_SPACE};
				ex.nrow    = bs_row;
				ex.ncol    = bs_col;
			end
			tce_pkg::MODE_CLEAR: begin
				ex.clear = 1'b1;
				ex.nrow  = '0;
				ex.ncol  = '0;
			end
			tce_pkg::MODE_READ: begin
				ex.addr = cell_addr(item.row, item.col);
				if (on_screen) begin
					ex.rd_en = 1'b1;
				end else begin
					ex.error = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/tce_outq.sv @@
// Two-entry result queue that drives the master-side stream.
module tce_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  tce_pkg::result_t             push_data,
	output logic                         full,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tce_pkg::TDATA_W-1:0]  m_tdata
);

	tce_pkg::result_t ent_q [2];
	tce_pkg::result_t head;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign pop      = m_tvalid && m_tready;
	assign full     = (cnt_q == 2'd2);
	assign m_tvalid = (cnt_q != 2'd0);
	assign head     = ent_q[rd_ptr_q];
	assign m_tdata  = {2'b00, head.cell_attr, head.cell_char, head.scrolled, head.error,
		head.cursor_col, head.cursor_row};

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ src/text_console_engine_top.sv @@
// Top level of the text console engine: sequencer, cursor, settings and cell store.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid/s_tready    s_tdata: operation item
//   m_*      out        m_tvalid/m_tready    m_tdata: result item
//   cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data: register write
//
// Put, backspace and unused modes go to ST_EXEC, which writes at most one cell;
// a cell read adds ST_RDWAIT for the registered RAM read.
// A scroll or a clear sweeps all ROWS*COLUMNS cells, one cell per cycle
// through the single write and read port of the store.
// After reset a clearing pass over all ROWS*COLUMNS cells zeroes the store with
// s_tready low; configuration writes are always taken.
// Results wait in a two-entry queue, so a stalled m_tready stalls input only once
// both entries are full.
module text_console_engine_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// mode[2:0], ch[10:3], row[15:11], col[22:16], attr[30:23], zero[31]
	input  logic [tce_pkg::TDATA_W-1:0]    s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// cursor_row[4:0], cursor_col[11:5], error[12], scrolled[13],
	// cell_char[21:14], cell_attr[29:22], zero[31:30]
	output logic [tce_pkg::TDATA_W-1:0]    m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tce_pkg::ATTR_W-1:0]     cfg_data
);

	tce_pkg::state_t  state_q, state_d;
	tce_pkg::item_t   item_q;
	tce_pkg::exec_t   ex;
	tce_pkg::result_t res_q;
	tce_pkg::result_t push_data;

	logic [tce_pkg::ROW_W-1:0]  cur_row_q;
	logic [tce_pkg::COL_W-1:0]  cur_col_q;
	logic [tce_pkg::ATTR_W-1:0] dflt_attr_q;
	logic [tce_pkg::ATTR_W-1:0] err_attr_q;
	logic [tce_pkg::ADDR_W-1:0] sweep_q;
	logic                       sweep_last;
	logic [tce_pkg::ADDR_W:0]   scroll_src;

	logic                       scr_wr_s1;
	logic [tce_pkg::ADDR_W-1:0] scr_addr_s1;
	logic                       scr_zero_s1;

	logic                       ram_we;
	logic [tce_pkg::ADDR_W-1:0] ram_waddr;
	logic [tce_pkg::CELL_W-1:0] ram_wdata;
	logic [tce_pkg::ADDR_W-1:0] ram_raddr;
	logic [tce_pkg::CELL_W-1:0] ram_rdata;

	logic push;
	logic q_full;
	logic in_xfer;

	assign cfg_ready  = 1'b1;
	assign in_xfer    = s_tvalid && s_tready;
	assign sweep_last = (sweep_q == tce_pkg::LAST_CELL);
	assign scroll_src = {1'b0, sweep_q} + tce_pkg::ADDR_COLS;

	tce_exec u_exec (
		.item      (item_q),
		.cur_row   (cur_row_q),
		.cur_col   (cur_col_q),
		.dflt_attr (dflt_attr_q),
		.err_attr  (err_attr_q),
		.ex        (ex)
	);

	tce_ram #(
		.WIDTH (tce_pkg::CELL_W),
		.DEPTH (tce_pkg::CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tce_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tce_pkg::ST_INIT: begin
				if (sweep_last) begin
					state_d = tce_pkg::ST_IDLE;
				end
			end
			tce_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = tce_pkg::ST_EXEC;
				end
			end
			tce_pkg::ST_EXEC: begin
				priority if (ex.clear) begin
					state_d = tce_pkg::ST_FILL;
				end else if (ex.scroll) begin
					state_d = tce_pkg::ST_SCROLL;
				end else if (ex.rd_en) begin
					state_d = tce_pkg::ST_RDWAIT;
				end else begin
					state_d = tce_pkg::ST_IDLE;
				end
			end
			tce_pkg::ST_RDWAIT: begin
				state_d = tce_pkg::ST_IDLE;
			end
			tce_pkg::ST_SCROLL, tce_pkg::ST_FILL: begin
				if (sweep_last) begin
					state_d = tce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tce_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ex.addr;
		ram_wdata = ex.wr_data;
		ram_raddr = ex.addr;
		push      = 1'b0;
		push_data = res_q;
		unique case (state_q)
			tce_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = '0;
			end
			tce_pkg::ST_IDLE: begin
				s_tready = !q_full;
			end
			tce_pkg::ST_EXEC: begin
				ram_we    = ex.wr_en;
				push      = !(ex.clear || ex.scroll || ex.rd_en);
				push_data = '{cursor_row: ex.nrow, cursor_col: ex.ncol, error: ex.error,
					scrolled: 1'b0, cell_char: '0, cell_attr: '0};
			end
			tce_pkg::ST_RDWAIT: begin
				push                = 1'b1;
				push_data.cell_char = ram_rdata[tce_pkg::CH_W-1:0];
				push_data.cell_attr = ram_rdata[tce_pkg::CELL_W-1:tce_pkg::CH_W];
			end
			tce_pkg::ST_SCROLL: begin
				ram_raddr = scroll_src[tce_pkg::ADDR_W-1:0];
				push      = sweep_last;
			end
			tce_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = {dflt_attr_q, tce_pkg::CH_SPACE};
				push      = sweep_last;
			end
			default: begin
			end
		endcase
		if (scr_wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = scr_addr_s1;
			ram_wdata = scr_zero_s1 ? '0 : ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q.mode <= s_tdata[2:0];
			item_q.ch   <= s_tdata[10:3];
			item_q.row  <= s_tdata[15:11];
			item_q.col  <= s_tdata[22:16];
			item_q.attr <= s_tdata[30:23];
		end
		if (state_q == tce_pkg::ST_EXEC) begin
			res_q <= '{cursor_row: ex.nrow, cursor_col: ex.ncol, error: ex.error,
				scrolled: ex.scroll, cell_char: '0, cell_attr: '0};
		end
		scr_addr_s1 <= sweep_q;
		scr_zero_s1 <= (sweep_q >= tce_pkg::LAST_ROW_START);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tce_pkg::ST_INIT;
			sweep_q     <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			dflt_attr_q <= tce_pkg::RESET_DEFAULT_ATTR;
			err_attr_q  <= tce_pkg::RESET_ERROR_ATTR;
			scr_wr_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			scr_wr_s1 <= (state_q == tce_pkg::ST_SCROLL);
			if (state_q == tce_pkg::ST_INIT || state_q == tce_pkg::ST_SCROLL
				|| state_q == tce_pkg::ST_FILL) begin
				sweep_q <= sweep_last ? '0 : sweep_q + {{(tce_pkg::ADDR_W - 1){1'b0}}, 1'b1};
			end
			if (state_q == tce_pkg::ST_EXEC) begin
				cur_row_q <= ex.nrow;
				cur_col_q <= ex.ncol;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tce_pkg::CFG_DEFAULT_ATTR) begin
					dflt_attr_q <= cfg_data;
				end else if (cfg_index == tce_pkg::CFG_ERROR_ATTR) begin
					err_attr_q <= cfg_data;
				end
			end
		end
	end

endmodule

@@ src/tce_checker.sv @@
// Port-level assertions of the text console engine and their bind.
module tce_port_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tce_pkg::TDATA_W-1:0]    m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[4:0]} < tce_pkg::ROWS_X)
			&& ({1'b0, m_tdata[11:5]} < tce_pkg::COLS_X))
		else $error("cursor outside the screen");

	a_err_no_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[12] && m_tdata[13]))
		else $error("error and scroll reported together");

endmodule

bind text_console_engine_top tce_port_props u_tce_port_props (.*);

@@ sim/tce_checker.sv @@
// Status checker for the text console engine: mirrors the screen, predicts and compares.
module tce_checker
	import tce_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [TDATA_W-1:0]   m_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ATTR_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding,
	output int                   statuses_seen,
	output int                   scroll_total,
	output int                   error_total
);

	localparam int OP_CH_LSB   = MODE_W;
	localparam int OP_ROW_LSB  = OP_CH_LSB + CH_W;
	localparam int OP_COL_LSB  = OP_ROW_LSB + ROW_W;
	localparam int OP_ATTR_LSB = OP_COL_LSB + COL_W;

	localparam int ST_COL_LSB  = ROW_W;
	localparam int ST_ERR_BIT  = ST_COL_LSB + COL_W;
	localparam int ST_SCR_BIT  = ST_ERR_BIT + 1;
	localparam int ST_CH_LSB   = ST_SCR_BIT + 1;
	localparam int ST_ATTR_LSB = ST_CH_LSB + CH_W;

	logic [CH_W-1:0]   glyph_mem [CELL_COUNT];
	logic [ATTR_W-1:0] shade_mem [CELL_COUNT];
	int unsigned       cursor_pos;
	logic [ATTR_W-1:0] dflt_attr;
	logic [ATTR_W-1:0] err_attr;
	result_t           status_q [$];
	int                miss_n;
	int                seen_n;
	int                scroll_n;
	int                err_n;

	function automatic void scroll_screen();
		for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
			glyph_mem[i] = glyph_mem[i + COLUMNS];
			shade_mem[i] = shade_mem[i + COLUMNS];
		end
		for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
			glyph_mem[i] = '0;
			shade_mem[i] = '0;
		end
	endfunction

	function automatic bit write_glyph(input int unsigned pos, input logic [CH_W-1:0] ch,
			input logic [ATTR_W-1:0] at);
		int unsigned nxt;
		bit wrapped;
		nxt = pos;
		wrapped = 1'b0;
		if (ch == CH_NEWLINE) begin
			nxt = (pos / COLUMNS + 1) * COLUMNS;
		end else if (ch == CH_BLANK) begin
			glyph_mem[pos] = CH_SPACE;
			shade_mem[pos] = at;
		end else begin
			glyph_mem[pos] = ch;
			shade_mem[pos] = at;
			nxt = pos + 1;
		end
		if (nxt >= CELL_COUNT) begin
			scroll_screen();
			nxt -= COLUMNS;
			wrapped = 1'b1;
		end
		cursor_pos = nxt;
		return wrapped;
	endfunction

	function automatic result_t console_apply(input logic [TDATA_W-1:0] word);
		logic [MODE_W-1:0] mode;
		logic [CH_W-1:0]   ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ATTR_W-1:0] at;
		int unsigned       pos;
		bit                on_screen;
		result_t           r;
		mode = word[0 +: MODE_W];
		ch   = word[OP_CH_LSB +: CH_W];
		row  = word[OP_ROW_LSB +: ROW_W];
		col  = word[OP_COL_LSB +: COL_W];
		at   = word[OP_ATTR_LSB +: ATTR_W];
		r = '0;
		on_screen = (int'(row) < ROWS) && (int'(col) < COLUMNS);
		pos = int'(row) * COLUMNS + int'(col);
		if (at == '0)
			at = dflt_attr;
		case (mode)
			MODE_PUT_CUR: begin
				r.scrolled = write_glyph(cursor_pos, ch, at);
			end
			MODE_PUT_POS: begin
				if (!on_screen) begin
					glyph_mem[CELL_COUNT-1] = CH_ERROR;
					shade_mem[CELL_COUNT-1] = err_attr;
					r.error = 1'b1;
				end else begin
					r.scrolled = write_glyph(pos, ch, at);
				end
			end
			MODE_BACKSPACE: begin
				void'(write_glyph((cursor_pos == 0) ? 0 : cursor_pos - 1, CH_BLANK, dflt_attr));
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++) begin
					glyph_mem[i] = CH_SPACE;
					shade_mem[i] = dflt_attr;
				end
				cursor_pos = 0;
			end
			MODE_READ: begin
				if (!on_screen) begin
					r.error = 1'b1;
				end else begin
					r.cell_char = glyph_mem[pos];
					r.cell_attr = shade_mem[pos];
				end
			end
			default: begin
			end
		endcase
		r.cursor_row = ROW_W'(cursor_pos / COLUMNS);
		r.cursor_col = COL_W'(cursor_pos % COLUMNS);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELL_COUNT; i++) begin
				glyph_mem[i] = '0;
				shade_mem[i] = '0;
			end
			cursor_pos = 0;
			dflt_attr = RESET_DEFAULT_ATTR;
			err_attr = RESET_ERROR_ATTR;
			status_q.delete();
			miss_n = 0;
			seen_n = 0;
			scroll_n = 0;
			err_n = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEFAULT_ATTR: dflt_attr = cfg_data;
					CFG_ERROR_ATTR:   err_attr = cfg_data;
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.cursor_row = m_tdata[0 +: ROW_W];
				got.cursor_col = m_tdata[ST_COL_LSB +: COL_W];
				got.error      = m_tdata[ST_ERR_BIT];
				got.scrolled   = m_tdata[ST_SCR_BIT];
				got.cell_char  = m_tdata[ST_CH_LSB +: CH_W];
				got.cell_attr  = m_tdata[ST_ATTR_LSB +: ATTR_W];
				seen_n++;
				if (status_q.size() == 0) begin
					miss_n++;
					if (miss_n <= 10)
						$display("unexpected status transfer: %h", m_tdata);
				end else begin
					want = status_q.pop_front();
					if (got !== want) begin
						miss_n++;
						if (miss_n <= 10)
							$display({"status %0d mismatch: row %0d/%0d col %0d/%0d err %b/%b ",
								"scr %b/%b char %h/%h attr %h/%h (expected/actual)"},
								seen_n, want.cursor_row, got.cursor_row,
								want.cursor_col, got.cursor_col, want.error, got.error,
								want.scrolled, got.scrolled, want.cell_char, got.cell_char,
								want.cell_attr, got.cell_attr);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = console_apply(s_tdata);
				if (want.scrolled)
					scroll_n++;
				if (want.error)
					err_n++;
				status_q.push_back(want);
			end
		end
		mismatches    <= miss_n;
		outstanding   <= status_q.size();
		statuses_seen <= seen_n;
		scroll_total  <= scroll_n;
		error_total   <= err_n;
	end

endmodule

@@ sim/testbench.sv @@
// Testbench top for the text console engine: clock, reset, traffic and verdict.
module testbench;
	import tce_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
	localparam int PHASES        = 5;
	localparam int PHASE_OPS     = 150;
	localparam int SETTLE_CYCLES = CELL_COUNT + 100;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_AFTER    = 60;
	localparam int RUN_LIMIT     = 100_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DEFAULT_ATTR;
	logic [ATTR_W-1:0]    cfg_data = '0;

	int mismatches;
	int outstanding;
	int statuses_seen;
	int scroll_total;
	int error_total;

	int               ops_sent = 0;
	int               burst_left = 0;
	bit               hold_done = 1'b0;
	logic [ROW_W-1:0] last_row = '0;
	logic [COL_W-1:0] last_col = '0;

	text_console_engine_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tce_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.statuses_seen(statuses_seen),
		.scroll_total (scroll_total),
		.error_total  (error_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("timeout with %0d statuses still expected", outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 15);
		return $urandom_range(16, 80);
	endfunction

	function automatic logic [TDATA_W-1:0] pack_op(input logic [MODE_W-1:0] mode,
			input logic [CH_W-1:0] ch, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [ATTR_W-1:0] attr);
		return TDATA_W'({attr, col, row, ch, mode});
	endfunction

	function automatic logic [TDATA_W-1:0] random_op();
		logic [MODE_W-1:0] mode;
		logic [CH_W-1:0]   ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ATTR_W-1:0] attr;
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			mode = MODE_PUT_CUR;
		else if (pick < 65)
			mode = MODE_PUT_POS;
		else if (pick < 73)
			mode = MODE_BACKSPACE;
		else if (pick < 75)
			mode = MODE_CLEAR;
		else if (pick < 95)
			mode = MODE_READ;
		else
			mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		pick = $urandom_range(0, 99);
		if (pick < 10)
			ch = CH_NEWLINE;
		else if (pick < 15)
			ch = CH_BLANK;
		else
			ch = CH_W'($urandom);
		attr = ($urandom_range(0, 4) == 0) ? '0 : ATTR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			row = ROW_W'($urandom_range(0, ROWS - 1));
			col = COL_W'($urandom_range(0, COLUMNS - 1));
		end else if (pick < 75) begin
			row = ROW_LAST;
			col = COL_W'($urandom_range(0, COLUMNS - 1));
		end else if (pick < 82) begin
			row = ROW_LAST;
			col = COL_LAST;
		end else if (pick < 90) begin
			row = last_row;
			col = last_col;
		end else begin
			row = ROW_W'($urandom);
			col = COL_W'($urandom);
		end
		if (mode == MODE_PUT_POS && int'(row) < ROWS && int'(col) < COLUMNS) begin
			last_row = row;
			last_col = col;
		end
		return pack_op(mode, ch, row, col, attr);
	endfunction

	task automatic push_op(input logic [TDATA_W-1:0] word);
		int gap;
		s_tdata <= word;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		ops_sent++;
		gap = (burst_left > 0) ? 0 : idle_gap();
		if (burst_left > 0)
			burst_left--;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_all();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ATTR_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : sink
		int gap;
		@(posedge clk);
		forever begin
			if (!hold_done && statuses_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 120)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				gap = idle_gap();
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin : source
		logic [ATTR_W-1:0] dflt;
		logic [ATTR_W-1:0] errc;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_op(pack_op(MODE_PUT_CUR, 8'h41, '0, '0, '0));
		push_op(pack_op(MODE_PUT_CUR, 8'hFF, '1, '1, 8'hFF));
		push_op(pack_op(MODE_PUT_CUR, 8'h00, '0, '0, 8'h01));
		push_op(pack_op(MODE_PUT_CUR, CH_BLANK, '0, '0, 8'h5A));
		push_op(pack_op(MODE_PUT_CUR, CH_NEWLINE, '0, '0, 8'h33));
		push_op(pack_op(MODE_BACKSPACE, 8'h41, '1, '1, 8'h77));
		push_op(pack_op(MODE_READ, '0, '0, COL_LAST, '0));
		push_op(pack_op(MODE_CLEAR, '1, '1, '1, '1));
		push_op(pack_op(MODE_BACKSPACE, '0, '0, '0, '0));
		push_op(pack_op(MODE_READ, '0, '0, '0, '0));
		push_op(pack_op(MODE_PUT_POS, 8'h78, '0, '0, '0));
		push_op(pack_op(MODE_PUT_POS, CH_NEWLINE, '0, 7'd40, 8'h11));
		push_op(pack_op(MODE_PUT_POS, 8'h5A, ROW_LAST, COL_LAST, 8'h80));
		push_op(pack_op(MODE_PUT_POS, 8'h61, ROW_W'(ROWS), '0, 8'h22));
		push_op(pack_op(MODE_PUT_POS, 8'h62, '0, COL_W'(COLUMNS), 8'h22));
		push_op(pack_op(MODE_PUT_POS, 8'h63, '1, '1, 8'h22));
		push_op(pack_op(MODE_READ, '0, ROW_LAST, COL_LAST, '0));
		push_op(pack_op(MODE_READ, '0, '1, '1, '0));
		push_op(pack_op(MODE_READ, '0, '0, COL_W'(COLUMNS), '0));
		push_op(pack_op(MODE_PUT_POS, CH_NEWLINE, ROW_LAST, 7'd5, '0));
		push_op(pack_op(MODE_PUT_POS, CH_BLANK, ROW_LAST, COL_LAST, 8'h9C));
		push_op(pack_op(MODE_READ, '0, ROW_LAST, COL_LAST, '0));
		for (logic [MODE_W:0] m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
			push_op(pack_op(MODE_W'(m), '1, '1, '1, '1));
		push_op(pack_op(MODE_PUT_CUR, 8'h71, '0, '0, '0));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_all();
			repeat (SETTLE_CYCLES) @(posedge clk);
			case (ph)
				0: begin
					dflt = '0;
					errc = '1;
				end
				1: begin
					dflt = '1;
					errc = '0;
				end
				default: begin
					dflt = ATTR_W'($urandom);
					errc = ATTR_W'($urandom);
				end
			endcase
			write_reg(CFG_DEFAULT_ATTR, dflt);
			write_reg(CFG_ERROR_ATTR, errc);
			burst_left = 30;
			for (int n = 0; n < PHASE_OPS; n++) begin
				push_op(random_op());
				if (n == PHASE_OPS / 2)
					drain_all();
			end
		end

		drain_all();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d operations and %0d statuses, %0d scrolls, %0d off-screen requests",
			ops_sent, statuses_seen, scroll_total, error_total);
		$display("attribute registers: reset values plus %0d written settings", PHASES);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d statuses never arrived", mismatches, outstanding);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
